[rtl/core/mws_pkg.sv]
// ----------------------------------------------------------------------------
// mws_pkg: shared types and constants for the window-sum block
// Register indexes, register widths and reset values, and the flags that
// travel from the front part to the back part with every cell.
// ----------------------------------------------------------------------------
package mws_pkg;

	// register map
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 2'd0,
		REG_GRID_COLS = 2'd1,
		REG_WIN_ROWS  = 2'd2,
		REG_WIN_COLS  = 2'd3
	} mws_reg_t;

	localparam int GRID_ROWS_W = 11;
	localparam int GRID_COLS_W = 11;
	localparam int WIN_ROWS_W  = 7;
	localparam int WIN_COLS_W  = 11;

	localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST = 11'd1024;
	localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 11'd1024;
	localparam logic [WIN_ROWS_W-1:0]  WIN_ROWS_RST  = 7'd1;
	localparam logic [WIN_COLS_W-1:0]  WIN_COLS_RST  = 11'd1;

	// grid height limit and row counter width
	localparam int GRID_ROW_LIMIT = 1024;
	localparam int ROW_W          = 10;

	// result width
	localparam int SUM_W = 32;

	// per-cell classification
	typedef struct packed {
		logic fits;       // window fits in the grid
		logic first_row;  // row 0: old column sum counts as zero
		logic sub_line;   // drop the cell that leaves the column window
		logic hz_clear;   // column 0: restart the horizontal sum
		logic sub_h;      // drop the column sum that leaves the window
		logic elig;       // a full window ends at this cell
		logic last;       // last cell of the grid
	} mws_flags_t;

endpackage

[rtl/core/mws_ram.sv]
// ----------------------------------------------------------------------------
// mws_ram: generic simple dual-port RAM
// One write port, one read port with read enable and registered read data.
// ----------------------------------------------------------------------------
module mws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/mws_queue.sv]
// ----------------------------------------------------------------------------
// mws_queue: short FIFO between front and back
// Register-based queue; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module mws_queue #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;

	assign full     = (int'(count_q) == DEPTH);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/mws_front.sv]
// ----------------------------------------------------------------------------
// mws_front: configuration, raster tracking and cell classification
// Holds the size registers, walks row and column positions and the line
// store slot, and pushes each cell with its addresses and flags.
// ----------------------------------------------------------------------------
module mws_front #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_WIN_ROWS = 64,
	parameter int CELL_BITS    = 16,
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int SLOT_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [mws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mws_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          cell_valid,
	output logic                          cell_ready,
	input  logic signed [CELL_BITS-1:0]   cell_value,
	input  logic                          q_full,
	output logic                          q_push,
	output logic signed [CELL_BITS-1:0]   q_value,
	output logic [COL_W-1:0]              q_col,
	output logic [SLOT_W+COL_W-1:0]       q_line,
	output logic [COL_W-1:0]              q_sub,
	output mws_pkg::mws_flags_t           q_flags
);

	import mws_pkg::*;

	logic [GRID_ROWS_W-1:0] grid_rows_q;
	logic [GRID_COLS_W-1:0] grid_cols_q;
	logic [WIN_ROWS_W-1:0]  win_rows_q;
	logic [WIN_COLS_W-1:0]  win_cols_q;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;

	logic [ROW_W:0] gr_eff;
	logic [COL_W:0] gc_eff;
	logic           fits;
	logic           last_col;
	logic           last_row;
	logic           accept;

	// clamp grid sizes
	always_comb begin
		if (grid_rows_q == '0) begin
			gr_eff = (ROW_W+1)'(1);
		end else if (int'(grid_rows_q) > GRID_ROW_LIMIT) begin
			gr_eff = (ROW_W+1)'(GRID_ROW_LIMIT);
		end else begin
			gr_eff = (ROW_W+1)'(grid_rows_q);
		end
		if (grid_cols_q == '0) begin
			gc_eff = (COL_W+1)'(1);
		end else if (int'(grid_cols_q) > MAX_COLS) begin
			gc_eff = (COL_W+1)'(MAX_COLS);
		end else begin
			gc_eff = (COL_W+1)'(grid_cols_q);
		end
	end

	assign fits = (win_rows_q != '0) && (int'(win_rows_q) <= MAX_WIN_ROWS) &&
	              (int'(win_rows_q) <= int'(gr_eff)) &&
	              (win_cols_q != '0) && (int'(win_cols_q) <= int'(gc_eff));

	assign last_col = (int'(col_q) == int'(gc_eff) - 1);
	assign last_row = (int'(row_q) == int'(gr_eff) - 1);

	assign cell_ready = !q_full;
	assign accept     = cell_valid && cell_ready;
	assign q_push     = accept;

	assign q_value = cell_value;
	assign q_col   = col_q;
	assign q_line  = {slot_q, col_q};
	assign q_sub   = COL_W'(int'(col_q) - int'(win_cols_q));

	always_comb begin
		q_flags           = '0;
		q_flags.fits      = fits;
		q_flags.first_row = (row_q == '0);
		q_flags.sub_line  = (int'(row_q) >= int'(win_rows_q));
		q_flags.hz_clear  = (col_q == '0);
		q_flags.sub_h     = (int'(col_q) >= int'(win_cols_q));
		q_flags.elig      = (int'(row_q) + 1 >= int'(win_rows_q)) &&
		                    (int'(col_q) + 1 >= int'(win_cols_q));
		q_flags.last      = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_ROWS_RST;
			grid_cols_q <= GRID_COLS_RST;
			win_rows_q  <= WIN_ROWS_RST;
			win_cols_q  <= WIN_COLS_RST;
			row_q       <= '0;
			col_q       <= '0;
			slot_q      <= '0;
		end else if (cfg_write) begin
			unique case (mws_reg_t'(cfg_index))
				REG_GRID_ROWS: grid_rows_q <= cfg_data[GRID_ROWS_W-1:0];
				REG_GRID_COLS: grid_cols_q <= cfg_data[GRID_COLS_W-1:0];
				REG_WIN_ROWS:  win_rows_q  <= cfg_data[WIN_ROWS_W-1:0];
				REG_WIN_COLS:  win_cols_q  <= cfg_data[WIN_COLS_W-1:0];
				default:       grid_rows_q <= grid_rows_q;
			endcase
			// restart the grid
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (last_row && last_col) begin
				row_q  <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end else if (last_col) begin
				col_q  <= '0;
				row_q  <= row_q + 1'b1;
				slot_q <= (fits && (int'(slot_q) + 1 < int'(win_rows_q))) ?
				          slot_q + 1'b1 : '0;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/mws_back.sv]
// ----------------------------------------------------------------------------
// mws_back: column and window sums, running maximum, result register
// Reads the line store and column sums, updates them with forwarding,
// tracks the best window sum and holds the result for the output channel.
// ----------------------------------------------------------------------------
module mws_back #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_WIN_ROWS = 64,
	parameter int CELL_BITS    = 16,
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int SLOT_W = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic signed [CELL_BITS-1:0]       q_value,
	input  logic [COL_W-1:0]                  q_col,
	input  logic [SLOT_W+COL_W-1:0]           q_line,
	input  logic [COL_W-1:0]                  q_sub,
	input  mws_pkg::mws_flags_t               q_flags,
	output logic                              sum_valid,
	input  logic                              sum_ready,
	output logic signed [mws_pkg::SUM_W-1:0]  max_sum,
	output logic                              result_valid
);

	import mws_pkg::*;

	localparam int MWR_LOG = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 0;
	localparam int CSUM_W  = CELL_BITS + MWR_LOG + 1;
	localparam int HSUM_W  = (CSUM_W + COL_W > SUM_W) ? CSUM_W + COL_W : SUM_W;
	localparam int LINE_D  = 2 ** (SLOT_W + COL_W);
	localparam int COL_D   = 2 ** COL_W;
	localparam logic signed [HSUM_W-1:0] BEST_INIT = {{(HSUM_W-SUM_W+1){1'b1}},
	                                                  {(SUM_W-1){1'b0}}};

	// stage 1: memory data present
	logic                        s1_valid_q;
	logic signed [CELL_BITS-1:0] value_s1;
	logic [COL_W-1:0]            col_s1;
	logic [SLOT_W+COL_W-1:0]     line_s1;
	mws_flags_t                  flags_s1;
	logic                        fwd_col_s1;
	logic                        fwd_sub_s1;
	logic                        fwd_line_s1;
	logic signed [CSUM_W-1:0]    fwd_csum_s1;
	logic signed [CELL_BITS-1:0] fwd_lval_s1;

	// stage 2: candidate compare
	logic                        s2_valid_q;
	logic signed [HSUM_W-1:0]    cand_s2;
	logic                        elig_s2;
	logic                        last_s2;
	logic                        fits_s2;

	logic signed [HSUM_W-1:0]    hsum_q;
	logic signed [HSUM_W-1:0]    best_q;
	logic                        out_valid_q;
	logic signed [SUM_W-1:0]     max_sum_q;
	logic                        result_valid_q;

	logic [CSUM_W-1:0]           col_rd;
	logic [CSUM_W-1:0]           sub_rd;
	logic [CELL_BITS-1:0]        line_rd;

	logic                        s1_fire;
	logic                        s2_fire;
	logic                        wr_en;
	logic signed [CSUM_W-1:0]    old_col;
	logic signed [CSUM_W-1:0]    sub_col;
	logic signed [CELL_BITS-1:0] old_line;
	logic signed [CSUM_W-1:0]    col_base;
	logic signed [CSUM_W-1:0]    line_term;
	logic signed [CSUM_W-1:0]    col_new;
	logic signed [HSUM_W-1:0]    hsum_base;
	logic signed [HSUM_W-1:0]    sub_term;
	logic signed [HSUM_W-1:0]    hsum_new;
	logic signed [HSUM_W-1:0]    best_next;

	// handshake between stages
	assign s2_fire = s2_valid_q && (!last_s2 || !out_valid_q || sum_ready);
	assign s1_fire = s1_valid_q && (!s2_valid_q || s2_fire);
	assign q_pop   = !q_empty && (!s1_valid_q || s1_fire);
	assign wr_en   = s1_fire && flags_s1.fits;

	// line store and two copies of the column sums
	mws_ram #(.WIDTH(CELL_BITS), .DEPTH(LINE_D)) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (line_s1),
		.wdata (value_s1),
		.re    (q_pop),
		.raddr (q_line),
		.rdata (line_rd)
	);

	mws_ram #(.WIDTH(CSUM_W), .DEPTH(COL_D)) u_col_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (col_new),
		.re    (q_pop),
		.raddr (q_col),
		.rdata (col_rd)
	);

	mws_ram #(.WIDTH(CSUM_W), .DEPTH(COL_D)) u_sub_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (col_new),
		.re    (q_pop),
		.raddr (q_sub),
		.rdata (sub_rd)
	);

	// column and horizontal sums
	always_comb begin
		old_col   = fwd_col_s1 ? fwd_csum_s1 : $signed(col_rd);
		sub_col   = fwd_sub_s1 ? fwd_csum_s1 : $signed(sub_rd);
		old_line  = fwd_line_s1 ? fwd_lval_s1 : $signed(line_rd);
		col_base  = flags_s1.first_row ? '0 : old_col;
		line_term = flags_s1.sub_line ? CSUM_W'(old_line) : '0;
		col_new   = col_base - line_term + CSUM_W'(value_s1);
		hsum_base = flags_s1.hz_clear ? '0 : hsum_q;
		sub_term  = flags_s1.sub_h ? HSUM_W'(sub_col) : '0;
		hsum_new  = hsum_base + HSUM_W'(col_new) - sub_term;
	end

	assign best_next = (elig_s2 && (cand_s2 > best_q)) ? cand_s2 : best_q;

	// stage payloads
	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_s1    <= q_value;
			col_s1      <= q_col;
			line_s1     <= q_line;
			flags_s1    <= q_flags;
			// forward the write that lands in the same cycle as the read
			fwd_col_s1  <= wr_en && (q_col == col_s1);
			fwd_sub_s1  <= wr_en && (q_sub == col_s1);
			fwd_line_s1 <= wr_en && (q_line == line_s1);
			fwd_csum_s1 <= col_new;
			fwd_lval_s1 <= value_s1;
		end
		if (wr_en) begin
			hsum_q <= hsum_new;
		end
		if (s1_fire) begin
			cand_s2 <= hsum_new;
			elig_s2 <= flags_s1.fits && flags_s1.elig;
			last_s2 <= flags_s1.last;
			fits_s2 <= flags_s1.fits;
		end
		if (s2_fire && last_s2) begin
			max_sum_q      <= fits_s2 ? best_next[SUM_W-1:0] : '0;
			result_valid_q <= fits_s2;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			best_q      <= BEST_INIT;
		end else begin
			if (q_pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				s2_valid_q <= 1'b1;
			end else if (s2_fire) begin
				s2_valid_q <= 1'b0;
			end
			// load a new result, or drop the one taken by the receiver
			if (s2_fire && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (sum_ready) begin
				out_valid_q <= 1'b0;
			end
			priority if (restart) begin
				best_q <= BEST_INIT;
			end else if (s2_fire && last_s2) begin
				best_q <= BEST_INIT;
			end else if (s2_fire) begin
				best_q <= best_next;
			end
		end
	end

	assign sum_valid    = out_valid_q;
	assign max_sum      = max_sum_q;
	assign result_valid = result_valid_q;

endmodule

[rtl/core/max_window_sum_2d.sv]
// ----------------------------------------------------------------------------
// max_window_sum_2d: largest fixed-size window sum over a raster grid
// Cells stream in row by row; after the last cell of a grid the block
// returns the largest sum over every window-sized rectangle in the grid.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  --------  ---------------------  --------------------------------------
//  cell      cell_valid/cell_ready  cell_value (signed, CELL_BITS)
//  sum       sum_valid/sum_ready    max_sum (signed 32), result_valid
//  cfg       cfg_write              cfg_index, cfg_data (no wait, no read)
//
//  One cell per cycle sustained while the result side keeps up; sum_valid
//  rises once the last cell of a grid has passed the queue, the memory read
//  stage and the compare stage into the result register. The per-cycle limit
//  is the single read port of each RAM.
//  Reset clears control state only; the line store is not cleared and
//  needs no clearing pass, since each entry is written before it is read.
//  A held result stalls only the last cell of the following grid; the
//  four-entry request queue absorbs back-end stalls before the input stalls.
// ----------------------------------------------------------------------------
module max_window_sum_2d #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_WIN_ROWS = 64,
	parameter int CELL_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write,
	input  logic [mws_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mws_pkg::CFG_W-1:0]         cfg_data,
	// cells in
	input  logic                              cell_valid,
	output logic                              cell_ready,
	input  logic signed [CELL_BITS-1:0]       cell_value,
	// result out
	output logic                              sum_valid,
	input  logic                              sum_ready,
	output logic signed [mws_pkg::SUM_W-1:0]  max_sum,
	output logic                              result_valid
);

	import mws_pkg::*;

	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SLOT_W  = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
	localparam int LINE_AW = SLOT_W + COL_W;
	localparam int FLAG_W  = $bits(mws_flags_t);
	localparam int Q_W     = CELL_BITS + COL_W + LINE_AW + COL_W + FLAG_W;
	localparam int Q_DEPTH = 4;

	// front side of the queue
	logic                        f_push;
	logic                        f_full;
	logic signed [CELL_BITS-1:0] f_value;
	logic [COL_W-1:0]            f_col;
	logic [LINE_AW-1:0]          f_line;
	logic [COL_W-1:0]            f_sub;
	mws_flags_t                  f_flags;

	// back side of the queue
	logic                        b_pop;
	logic                        b_empty;
	logic [Q_W-1:0]              b_data;
	logic signed [CELL_BITS-1:0] b_value;
	logic [COL_W-1:0]            b_col;
	logic [LINE_AW-1:0]          b_line;
	logic [COL_W-1:0]            b_sub;
	mws_flags_t                  b_flags;

	// accept cells, track the raster position and classify each cell
	mws_front #(
		.MAX_COLS     (MAX_COLS),
		.MAX_WIN_ROWS (MAX_WIN_ROWS),
		.CELL_BITS    (CELL_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.cell_value (cell_value),
		.q_full     (f_full),
		.q_push     (f_push),
		.q_value    (f_value),
		.q_col      (f_col),
		.q_line     (f_line),
		.q_sub      (f_sub),
		.q_flags    (f_flags)
	);

	// hold classified requests so each side can stall on its own
	mws_queue #(
		.WIDTH (Q_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_value, f_col, f_line, f_sub, f_flags}),
		.full      (f_full),
		.pop       (b_pop),
		.pop_data  (b_data),
		.empty     (b_empty)
	);

	assign {b_value, b_col, b_line, b_sub, b_flags} = b_data;

	// sums, maximum and result register; a register write resets the maximum
	mws_back #(
		.MAX_COLS     (MAX_COLS),
		.MAX_WIN_ROWS (MAX_WIN_ROWS),
		.CELL_BITS    (CELL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.restart      (cfg_write),
		.q_empty      (b_empty),
		.q_pop        (b_pop),
		.q_value      (b_value),
		.q_col        (b_col),
		.q_line       (b_line),
		.q_sub        (b_sub),
		.q_flags      (b_flags),
		.sum_valid    (sum_valid),
		.sum_ready    (sum_ready),
		.max_sum      (max_sum),
		.result_valid (result_valid)
	);

endmodule

[verif/max_window_sum_2d_check.sv]
// ----------------------------------------------------------------------------
// max_window_sum_2d_check: result predictor and comparator
// Follows register writes and accepted cell requests, works out the largest
// window sum of every grid and compares it with each result the block hands
// over.
// ----------------------------------------------------------------------------
module max_window_sum_2d_check #(
	parameter int MAX_COLS     = 1024,
	parameter int MAX_WIN_ROWS = 64,
	parameter int CELL_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mws_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                cell_valid,
	input  logic                                cell_ready,
	input  logic signed [CELL_BITS-1:0]         cell_value,
	input  logic                                sum_valid,
	input  logic                                sum_ready,
	input  logic signed [mws_pkg::SUM_W-1:0]    max_sum,
	input  logic                                result_valid,
	output int                                  mismatches,
	output int                                  maxima_owed
);

	import mws_pkg::*;

	localparam int COL_W = CELL_BITS + $clog2(MAX_WIN_ROWS) + 1;
	localparam logic signed [SUM_W-1:0] MOST_NEGATIVE = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct {
		logic signed [SUM_W-1:0] sum;
		logic                    fits;
	} grid_max_t;

	logic [GRID_ROWS_W-1:0] grid_rows;
	logic [GRID_COLS_W-1:0] grid_cols;
	logic [WIN_ROWS_W-1:0]  win_rows;
	logic [WIN_COLS_W-1:0]  win_cols;

	logic signed [CELL_BITS-1:0] line_mem [MAX_WIN_ROWS*MAX_COLS];
	logic signed [COL_W-1:0]     col_sum  [MAX_COLS];
	logic signed [SUM_W-1:0]     row_sum;
	logic signed [SUM_W-1:0]     best_sum;
	int unsigned                 row_pos, col_pos, slot;

	grid_max_t queued_maxima [$];

	function automatic void restart_grid();
		foreach (col_sum[i])
			col_sum[i] = '0;
		row_sum  = '0;
		best_sum = MOST_NEGATIVE;
		row_pos  = 0;
		col_pos  = 0;
		slot     = 0;
	endfunction

	function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		case (mws_reg_t'(idx))
			REG_GRID_ROWS: grid_rows = val[GRID_ROWS_W-1:0];
			REG_GRID_COLS: grid_cols = val[GRID_COLS_W-1:0];
			REG_WIN_ROWS:  win_rows  = val[WIN_ROWS_W-1:0];
			REG_WIN_COLS:  win_cols  = val[WIN_COLS_W-1:0];
			default: ;
		endcase
		restart_grid();
	endfunction

	// Fold one cell into the column sums and the running row sum; queue the
	// grid maximum on the last cell.
	function automatic void accumulate_cell(input logic signed [CELL_BITS-1:0] v);
		int unsigned             gr, gc, r, c, idx;
		logic                    fits;
		logic signed [COL_W-1:0] col;
		grid_max_t               res;
		gr = grid_rows;
		gc = grid_cols;
		if (gr == 0) gr = 1;
		if (gr > GRID_ROW_LIMIT) gr = GRID_ROW_LIMIT;
		if (gc == 0) gc = 1;
		if (gc > MAX_COLS) gc = MAX_COLS;
		fits = win_rows >= 1 && win_rows <= MAX_WIN_ROWS && win_rows <= gr &&
			win_cols >= 1 && win_cols <= gc;
		r = (row_pos >= gr) ? gr - 1 : row_pos;
		c = (col_pos >= gc) ? gc - 1 : col_pos;

		if (fits) begin
			idx = (slot % MAX_WIN_ROWS) * MAX_COLS + c;
			col = (r == 0) ? '0 : col_sum[c];
			if (r >= win_rows)
				col = col - line_mem[idx];
			col = col + v;
			line_mem[idx] = v;
			col_sum[c]    = col;
			if (c == 0)
				row_sum = '0;
			row_sum = row_sum + col;
			if (c >= win_cols)
				row_sum = row_sum - col_sum[c - win_cols];
			if (r + 1 >= win_rows && c + 1 >= win_cols && row_sum > best_sum)
				best_sum = row_sum;
		end

		if (r == gr - 1 && c == gc - 1) begin
			res.sum  = fits ? best_sum : '0;
			res.fits = fits;
			queued_maxima.push_back(res);
			restart_grid();
		end else if (c + 1 >= gc) begin
			col_pos = 0;
			row_pos = r + 1;
			slot    = (fits && slot + 1 < win_rows) ? slot + 1 : 0;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grid_max_t want;
		if (!arst_n) begin
			grid_rows = GRID_ROWS_RST;
			grid_cols = GRID_COLS_RST;
			win_rows  = WIN_ROWS_RST;
			win_cols  = WIN_COLS_RST;
			restart_grid();
			queued_maxima.delete();
			mismatches  = 0;
			maxima_owed <= 0;
		end else begin
			if (sum_valid && sum_ready) begin
				if (queued_maxima.size() == 0) begin
					$display("%0t: unexpected result max_sum=%0d result_valid=%0b",
						$time, max_sum, result_valid);
					mismatches = mismatches + 1;
				end else begin
					want = queued_maxima.pop_front();
					if (max_sum !== want.sum) begin
						$display("%0t: max_sum expected %0d actual %0d",
							$time, want.sum, max_sum);
						mismatches = mismatches + 1;
					end
					if (result_valid !== want.fits) begin
						$display("%0t: result_valid expected %0b actual %0b",
							$time, want.fits, result_valid);
						mismatches = mismatches + 1;
					end
				end
			end
			if (cfg_write)
				write_reg(cfg_index, cfg_data);
			if (cell_valid && cell_ready)
				accumulate_cell(cell_value);
			maxima_owed <= queued_maxima.size();
		end
	end

endmodule

[verif/max_window_sum_2d_tb.sv]
// ----------------------------------------------------------------------------
// max_window_sum_2d_tb: stimulus and verdict for the window-sum block
// Streams grids of signed cells under many grid and window settings, with
// random gaps on the cell side and random stalls on the result side; a
// separate checker predicts every grid maximum and counts mismatches.
// ----------------------------------------------------------------------------
module max_window_sum_2d_tb;
	import mws_pkg::*;

	localparam int CELL_W     = 16;
	localparam int HOLD_LEN   = 400;  // long result hold-off, in cycles
	localparam int QUIET_LEN  = 16;   // lets the block's pipeline run dry

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_write;
	mws_reg_t                 cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     cell_valid;
	logic                     cell_ready;
	logic signed [CELL_W-1:0] cell_value;
	logic                     sum_valid;
	logic                     sum_ready;
	logic signed [SUM_W-1:0]  max_sum;
	logic                     result_valid;

	int mismatches;
	int maxima_owed;

	// idling odds in percent, and a one-shot request for a long hold-off
	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_off_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	max_window_sum_2d dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_valid   (cell_valid),
		.cell_ready   (cell_ready),
		.cell_value   (cell_value),
		.sum_valid    (sum_valid),
		.sum_ready    (sum_ready),
		.max_sum      (max_sum),
		.result_valid (result_valid)
	);

	max_window_sum_2d_check u_sum_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_valid   (cell_valid),
		.cell_ready   (cell_ready),
		.cell_value   (cell_value),
		.sum_valid    (sum_valid),
		.sum_ready    (sum_ready),
		.max_sum      (max_sum),
		.result_valid (result_valid),
		.mismatches   (mismatches),
		.maxima_owed  (maxima_owed)
	);

	// Result side: stall at random; on a hold-off request drop ready for a
	// long stretch so the block backs up into the cell channel.
	initial begin
		sum_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				sum_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end
			sum_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Mostly full-range values, with the extremes and the values around zero
	// showing up often.
	function automatic logic signed [CELL_W-1:0] pick_cell();
		case ($urandom_range(9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return $urandom_range(1) ? 16'sd0 : -16'sd1;
			default: return CELL_W'($urandom_range(65535));
		endcase
	endfunction

	// Offer one cell request; hold it until the block takes it. Valid stays
	// high afterwards so back-to-back requests never toggle it.
	task automatic put_cell(input logic signed [CELL_W-1:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			cell_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cell_valid <= 1'b1;
		cell_value <= v;
		do @(posedge clk); while (!cell_ready);
	endtask

	task automatic send_cells(input int n);
		repeat (n) put_cell(pick_cell());
	endtask

	// Stop offering, wait for every owed maximum, then let the pipeline run dry.
	task automatic settle();
		cell_valid <= 1'b0;
		do @(posedge clk); while (maxima_owed != 0);
		repeat (QUIET_LEN) @(posedge clk);
	endtask

	// Write all four registers on an idle block; each write restarts the grid.
	task automatic set_grid(input int gr, input int gc, input int wr, input int wc);
		settle();
		cfg_write <= 1'b1;
		cfg_index <= REG_GRID_ROWS;
		cfg_data  <= CFG_W'(gr);
		@(posedge clk);
		cfg_index <= REG_GRID_COLS;
		cfg_data  <= CFG_W'(gc);
		@(posedge clk);
		cfg_index <= REG_WIN_ROWS;
		cfg_data  <= CFG_W'(wr);
		@(posedge clk);
		cfg_index <= REG_WIN_COLS;
		cfg_data  <= CFG_W'(wc);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Pick a small grid: mostly windows that fit, some that are too tall,
	// too wide or empty, and some grids with a zero dimension.
	task automatic random_setting(output int cells);
		int gr, gc, wr, wc, kind;
		kind = $urandom_range(99);
		gr   = $urandom_range(6, 1);
		gc   = $urandom_range(8, 1);
		wr   = $urandom_range(gr, 1);
		wc   = $urandom_range(gc, 1);
		if (kind >= 95) begin
			if ($urandom_range(1)) begin
				gr = 0;
				wr = 1;
			end else begin
				gc = 0;
				wc = 1;
			end
		end else if (kind >= 93) begin
			wc = 0;
		end else if (kind >= 90) begin
			wr = 0;
		end else if (kind >= 85) begin
			wc = $urandom_range(2047, gc + 1);
		end else if (kind >= 80) begin
			wr = $urandom_range(127, gr + 1);
		end
		set_grid(gr, gc, wr, wc);
		cells = (gr == 0 ? 1 : gr) * (gc == 0 ? 1 : gc);
	endtask

	// One idling phase: whole grids back to back under one setting, now and
	// then cut short so the next register write restarts a half-done grid.
	task automatic random_phase(input int send_pct, input int recv_pct, input int n);
		int sent, cells, cut;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < n) begin
			random_setting(cells);
			repeat ($urandom_range(3, 1)) begin
				send_cells(cells);
				sent = sent + cells;
			end
			if (cells > 1 && $urandom_range(99) < 15) begin
				cut = $urandom_range(cells - 1, 1);
				send_cells(cut);
				sent = sent + cut;
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_write  <= 1'b0;
		cfg_index  <= REG_GRID_ROWS;
		cfg_data   <= '0;
		cell_valid <= 1'b0;
		cell_value <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_off_req   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: a huge grid, so a few cells give no result.
		send_cells(3);

		// Directed: extremes in a 1x1 window, then a full-grid window of the
		// most negative value.
		set_grid(2, 3, 1, 1);
		put_cell(-16'sd32768);
		put_cell(16'sd32767);
		put_cell(16'sd0);
		put_cell(-16'sd1);
		put_cell(16'sd1);
		put_cell(16'sd32767);
		set_grid(2, 2, 2, 2);
		repeat (4) put_cell(-16'sd32768);

		// Window taller than the grid, zero window sizes, zero grid sizes.
		set_grid(2, 2, 3, 1);
		send_cells(4);
		set_grid(0, 0, 1, 1);
		put_cell(-16'sd1);
		set_grid(1, 2, 0, 1);
		send_cells(2);
		set_grid(1, 1, 1, 0);
		send_cells(1);

		// Half a grid, then restart it with a register write.
		set_grid(3, 3, 2, 2);
		send_cells(4);

		// Saturated grid dimensions, each cut short by the next register write.
		set_grid(2047, 1, 2, 1);
		send_cells(5);
		set_grid(1, 2047, 1, 1024);
		send_cells(5);

		// Full-height line store with the slot wrapping, then a window taller
		// than the store.
		set_grid(70, 1, 64, 1);
		send_cells(70);
		set_grid(66, 1, 65, 1);
		send_cells(66);

		// Hold off results for a long stretch while grids keep coming, so the
		// block fills and stalls the cell channel.
		set_grid(2, 2, 1, 1);
		hold_off_req = 1'b1;
		repeat (10) send_cells(4);

		random_phase(0, 0, 130);
		random_phase(85, 0, 130);
		random_phase(0, 85, 130);
		random_phase(37, 37, 130);

		settle();
		if (mismatches == 0)
			$display("max_window_sum_2d_tb passed");
		else
			$display("max_window_sum_2d_tb failed");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("max_window_sum_2d_tb failed");
		$finish;
	end

endmodule
